[sv/prba_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// page run bitmap allocator. No dependencies.
package prba_pkg;

	localparam int PAGE_COUNT      = 1024;
	localparam int PAGE_SHIFT      = 12;
	localparam int WORD_BITS       = 64;
	localparam int WORD_COUNT      = PAGE_COUNT / WORD_BITS;
	localparam int CHUNK_BITS      = 8;
	localparam int CHUNK_COUNT     = PAGE_COUNT / CHUNK_BITS;

	localparam int PAGE_IDX_W      = $clog2(PAGE_COUNT);
	localparam int PAGE_CNT_W      = PAGE_IDX_W + 1;
	localparam int WORD_IDX_W      = $clog2(WORD_COUNT);
	localparam int CHUNK_IDX_W     = $clog2(CHUNK_COUNT);
	localparam int CHUNK_SEL_W     = $clog2(CHUNK_BITS);
	localparam int BIT_OFF_W       = $clog2(WORD_BITS) + 1;

	localparam logic [0:0] CMD_ALLOC   = 1'b0;
	localparam logic [0:0] CMD_RELEASE = 1'b1;

	localparam logic [1:0] STAT_DONE       = 2'd0;
	localparam logic [1:0] STAT_ALLOC_FAIL = 2'd1;
	localparam logic [1:0] STAT_REL_REJECT = 2'd2;

	localparam logic [1:0] CFG_WIN_BASE = 2'd0;
	localparam logic [1:0] CFG_WIN_LO   = 2'd1;
	localparam logic [1:0] CFG_WIN_HI   = 2'd2;

	localparam logic [10:0] WIN_HI_RESET = 11'd1024;

	typedef struct packed {
		logic capture;
		logic check;
		logic scan;
		logic mark;
		logic load_out;
	} prba_cmd_t;

	typedef struct packed {
		logic chk_fail;
		logic is_alloc;
		logic scan_hit;
		logic scan_last;
		logic mark_last;
		logic out_free;
	} prba_sts_t;

endpackage

[sv/prba_ctrl.sv]
// Sequencing controller for the page run allocator: accept, check, scan,
// mark, result. Uses prba_pkg for command/status types.
module prba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  prba_pkg::prba_sts_t sts,
	output prba_pkg::prba_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MARK,
		S_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.chk_fail) state_q <= S_RESULT;
					else if (sts.is_alloc) state_q <= S_SCAN;
					else state_q <= S_MARK;
				end
				S_SCAN: begin
					if (sts.scan_hit) state_q <= S_MARK;
					else if (sts.scan_last) state_q <= S_RESULT;
				end
				S_MARK: begin
					if (sts.mark_last) state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.capture  = (state_q == S_IDLE) && in_valid;
		cmd.check    = (state_q == S_CHECK);
		cmd.scan     = (state_q == S_SCAN);
		cmd.mark     = (state_q == S_MARK);
		cmd.load_out = (state_q == S_RESULT) && sts.out_free;
	end

endmodule

[sv/prba_dp.sv]
// Datapath: config registers, page bitmap, chunk scanner, run marker and
// result register. Driven by prba_ctrl; uses prba_pkg.
module prba_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic [0:0]          command,
	input  logic [31:0]         size_bytes,
	input  logic [31:0]         address,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         run_address,
	output logic [1:0]          status,
	input  prba_pkg::prba_cmd_t cmd,
	output prba_pkg::prba_sts_t sts
);

	localparam int PW = prba_pkg::PAGE_IDX_W;
	localparam int CW = prba_pkg::PAGE_CNT_W;
	localparam int KW = prba_pkg::CHUNK_IDX_W;
	localparam int WW = prba_pkg::WORD_IDX_W;
	localparam int SW = prba_pkg::CHUNK_SEL_W;
	localparam int OW = prba_pkg::BIT_OFF_W;
	localparam int PS = prba_pkg::PAGE_SHIFT;
	localparam int WB = prba_pkg::WORD_BITS;
	localparam int CB = prba_pkg::CHUNK_BITS;
	localparam logic [CW-1:0] PAGE_LIMIT = CW'(prba_pkg::PAGE_COUNT);

	// configuration
	logic [31:0]   base_q;
	logic [CW-1:0] first_cfg_q;
	logic [CW-1:0] end_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			first_cfg_q <= '0;
			end_cfg_q   <= prba_pkg::WIN_HI_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				prba_pkg::CFG_WIN_BASE: base_q      <= cfg_data;
				prba_pkg::CFG_WIN_LO:   first_cfg_q <= cfg_data[CW-1:0];
				prba_pkg::CFG_WIN_HI:   end_cfg_q   <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic [0:0]  cmd_q;
	logic [31:0] size_q;
	logic [31:0] addr_in_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= command;
			size_q    <= size_bytes;
			addr_in_q <= address;
		end
	end

	// working registers
	logic [CW-1:0] lo_q, hi_q;
	logic [CW-1:0] pages_q;
	logic [CW-1:0] run_q;
	logic [KW-1:0] chunk_q;
	logic [PW-1:0] mark_a_q;
	logic [CW-1:0] mark_b_q;
	logic          set_q;
	logic [31:0]   addr_q;
	logic [1:0]    status_q;

	logic [WB-1:0] bitmap_q [prba_pkg::WORD_COUNT];

	// --- check logic
	logic [31-PS:0] pages_full;
	logic [CW-1:0]  lo_sat, hi_sat, hi_m1;
	logic           alloc_fail;
	logic [31:0]    rel_diff;
	logic [31-PS:0] rel_first;
	logic [32-PS:0] rel_end;
	logic           rel_reject;

	always_comb begin
		pages_full = size_q[31:PS];
		lo_sat     = (first_cfg_q > PAGE_LIMIT) ? PAGE_LIMIT : first_cfg_q;
		hi_sat     = (end_cfg_q > PAGE_LIMIT) ? PAGE_LIMIT : end_cfg_q;
		hi_m1      = hi_sat - CW'(1);
		alloc_fail = (pages_full == '0) || (lo_sat > hi_sat) ||
			(pages_full > (32-PS)'(hi_sat - lo_sat));
		rel_diff   = addr_in_q - base_q;
		rel_first  = rel_diff[31:PS];
		rel_end    = (33-PS)'(rel_first) + (33-PS)'(pages_full);
		rel_reject = (addr_in_q < base_q) || (rel_diff[PS-1:0] != '0) ||
			(size_q[PS-1:0] != '0) || (rel_first >= (32-PS)'(PAGE_LIMIT)) ||
			(rel_end > (33-PS)'(PAGE_LIMIT));
	end

	// --- scan of one chunk, top page first
	logic [WB-1:0] scan_word;
	logic [CB-1:0] scan_bits;
	logic [CW-1:0] run_next;
	logic          hit;
	logic [SW-1:0] hit_sel;
	logic [PW-1:0] page_j;
	logic          free_j;
	logic [PW-1:0] hit_page;

	always_comb begin
		scan_word = bitmap_q[chunk_q[KW-1:KW-WW]];
		scan_bits = scan_word[chunk_q[KW-WW-1:0]*CB +: CB];
		run_next  = run_q;
		hit       = 1'b0;
		hit_sel   = '0;
		page_j    = '0;
		free_j    = 1'b0;
		for (int j = CB - 1; j >= 0; j--) begin
			page_j   = {chunk_q, SW'(j)};
			free_j   = !scan_bits[j] && ({1'b0, page_j} >= lo_q) &&
				({1'b0, page_j} < hi_q);
			run_next = free_j ? run_next + CW'(1) : '0;
			if (!hit && free_j && run_next == pages_q) begin
				hit     = 1'b1;
				hit_sel = SW'(j);
			end
		end
		hit_page = {chunk_q, hit_sel};
	end

	// --- mark/clear mask for the current word
	logic [WW-1:0] mark_w;
	logic [CW-1:0] wbase;
	logic [CW-1:0] b_m1;
	logic [OW-1:0] lo_off, hi_off;
	logic [WB-1:0] mark_mask;

	function automatic logic [WB-1:0] low_mask(input logic [OW-1:0] n);
		logic [WB-1:0] m;
		if (n[OW-1]) m = '1;
		else m = (WB'(1) << n[OW-2:0]) - WB'(1);
		return m;
	endfunction

	always_comb begin
		mark_w    = chunk_q[KW-1:KW-WW];
		wbase     = {1'b0, mark_w, (PW-WW)'(0)};
		b_m1      = mark_b_q - CW'(1);
		lo_off    = ({1'b0, mark_a_q} > wbase) ? OW'({1'b0, mark_a_q} - wbase) : '0;
		if (mark_b_q <= wbase) hi_off = '0;
		else if (mark_b_q >= wbase + CW'(WB)) hi_off = OW'(WB);
		else hi_off = OW'(mark_b_q - wbase);
		mark_mask = low_mask(hi_off) & ~low_mask(lo_off);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < prba_pkg::WORD_COUNT; i++) bitmap_q[i] <= '0;
		end else if (cmd.mark) begin
			if (set_q) bitmap_q[mark_w] <= bitmap_q[mark_w] | mark_mask;
			else bitmap_q[mark_w] <= bitmap_q[mark_w] & ~mark_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			addr_q <= '0;
			lo_q   <= lo_sat;
			hi_q   <= hi_sat;
			run_q  <= '0;
			if (cmd_q == prba_pkg::CMD_ALLOC) begin
				status_q <= alloc_fail ? prba_pkg::STAT_ALLOC_FAIL : prba_pkg::STAT_DONE;
				pages_q  <= pages_full[CW-1:0];
				chunk_q  <= hi_m1[PW-1:SW];
			end else begin
				status_q <= rel_reject ? prba_pkg::STAT_REL_REJECT : prba_pkg::STAT_DONE;
				pages_q  <= pages_full[CW-1:0];
				mark_a_q <= rel_first[PW-1:0];
				mark_b_q <= rel_end[CW-1:0];
				chunk_q  <= {rel_first[PW-1:PW-WW], (KW-WW)'(0)};
				set_q    <= 1'b0;
			end
		end else if (cmd.scan) begin
			if (hit) begin
				mark_a_q <= hit_page;
				mark_b_q <= {1'b0, hit_page} + pages_q;
				chunk_q  <= {hit_page[PW-1:PW-WW], (KW-WW)'(0)};
				set_q    <= 1'b1;
				addr_q   <= base_q + 32'({hit_page, PS'(0)});
			end else if (sts.scan_last) begin
				status_q <= prba_pkg::STAT_ALLOC_FAIL;
			end else begin
				chunk_q <= chunk_q - KW'(1);
				run_q   <= run_next;
			end
		end else if (cmd.mark) begin
			chunk_q <= chunk_q + KW'(CB);
		end
	end

	// result register
	logic        out_valid_q;
	logic [31:0] run_address_q;
	logic [1:0]  status_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			run_address_q <= addr_q;
			status_out_q  <= status_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign run_address = run_address_q;
	assign status      = status_out_q;

	always_comb begin
		sts           = '0;
		sts.is_alloc  = (cmd_q == prba_pkg::CMD_ALLOC);
		sts.chk_fail  = sts.is_alloc ? alloc_fail : rel_reject;
		sts.scan_hit  = hit;
		sts.scan_last = (chunk_q == lo_q[PW-1:SW]);
		sts.mark_last = (mark_b_q == {1'b0, mark_a_q}) || (mark_w == b_m1[PW-1:PW-WW]);
		sts.out_free  = !out_valid_q || !out_stall;
	end

endmodule

[sv/page_run_bitmap_allocator_unit.sv]
// Page run bitmap allocator top level. One item at a time; an allocate checks,
// scans chunks (8 pages per cycle, up to 128) and sets the bitmap words touched
// (one 64-bit word per cycle, up to 16); a release checks and clears the words
// touched (at least one); a failed check skips to the result. The next item is
// taken once the result is in the output register. Reset clears the whole
// bitmap (all pages free) at once and loads the register reset values.
module page_run_bitmap_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  command,
	input  logic [31:0] size_bytes,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] run_address,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	prba_pkg::prba_cmd_t cmd;
	prba_pkg::prba_sts_t sts;

	assign cfg_ready = 1'b1;

	prba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	prba_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (command),
		.size_bytes  (size_bytes),
		.address     (address),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.run_address (run_address),
		.status      (status),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

[tb/sv/tb_page_run_bitmap_allocator_unit.sv]
// Self-checking testbench for page_run_bitmap_allocator_unit: directed and random
// allocate/release beats checked against a behavioral page bitmap, under idles and stalls.
// Depends on prba_pkg and page_run_bitmap_allocator_unit.
module tb_page_run_bitmap_allocator_unit;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS  = 10;
	localparam int LIVE_KEEP    = 48;

	typedef struct packed {
		logic [0:0]  command;
		logic [31:0] size_bytes;
		logic [31:0] address;
	} page_op_t;

	typedef struct packed {
		logic [31:0] run_address;
		logic [1:0]  status;
	} op_outcome_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] size_bytes;
	} page_run_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [0:0]  command = prba_pkg::CMD_ALLOC;
	logic [31:0] size_bytes = '0;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] run_address;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = prba_pkg::CFG_WIN_BASE;
	logic [31:0] cfg_data = '0;

	// behavioral copy of the allocator state and registers
	logic [prba_pkg::PAGE_COUNT-1:0] page_used = '0;
	logic [31:0]                     win_base = '0;
	logic [10:0]                     win_lo = '0;
	logic [10:0]                     win_hi = prba_pkg::WIN_HI_RESET;

	page_op_t    item_queue[$];
	op_outcome_t pending_outcomes[$];
	page_run_t   live_runs[$];

	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_cycles_left = 0;
	logic in_fire = 1'b0;
	int   cfg_beats = 0;

	int cycle_count = 0;
	int error_count = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int allocs_granted = 0;
	int allocs_refused = 0;
	int releases_done = 0;
	int releases_rejected = 0;

	page_run_bitmap_allocator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.size_bytes (size_bytes),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.run_address(run_address),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void apply_register(input logic [1:0] idx, input logic [31:0] value);
		case (idx)
			prba_pkg::CFG_WIN_BASE: begin
				win_base = value;
			end
			prba_pkg::CFG_WIN_LO: begin
				win_lo = value[10:0];
			end
			prba_pkg::CFG_WIN_HI: begin
				win_hi = value[10:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Updates the page bitmap for one beat and returns what the block should answer.
	task automatic predict_page_op(input page_op_t op, output op_outcome_t res);
		int          pages;
		int          lo;
		int          hi;
		int          run;
		int          first;
		logic [31:0] offset;
		pages = int'(op.size_bytes >> prba_pkg::PAGE_SHIFT);
		res = '{run_address: '0, status: prba_pkg::STAT_DONE};
		if (op.command == prba_pkg::CMD_ALLOC) begin
			lo = (win_lo > prba_pkg::PAGE_COUNT) ? prba_pkg::PAGE_COUNT : int'(win_lo);
			hi = (win_hi > prba_pkg::PAGE_COUNT) ? prba_pkg::PAGE_COUNT : int'(win_hi);
			res.status = prba_pkg::STAT_ALLOC_FAIL;
			if (pages == 0 || lo > hi || pages > hi - lo)
				return;
			run = 0;
			// top-down: the first run long enough is the highest one
			for (int p = hi - 1; p >= lo; p--) begin
				if (page_used[p]) begin
					run = 0;
				end else begin
					run++;
					if (run == pages) begin
						for (int i = 0; i < pages; i++)
							page_used[p + i] = 1'b1;
						res.run_address = win_base + (32'(p) << prba_pkg::PAGE_SHIFT);
						res.status = prba_pkg::STAT_DONE;
						live_runs.push_back(page_run_t'{address: res.run_address,
							size_bytes: 32'(pages) << prba_pkg::PAGE_SHIFT});
						if (live_runs.size() > LIVE_KEEP)
							void'(live_runs.pop_front());
						return;
					end
				end
			end
			return;
		end
		offset = op.address - win_base;
		if (op.address < win_base || offset[prba_pkg::PAGE_SHIFT-1:0] != 0 ||
				op.size_bytes[prba_pkg::PAGE_SHIFT-1:0] != 0) begin
			res.status = prba_pkg::STAT_REL_REJECT;
			return;
		end
		first = int'(offset >> prba_pkg::PAGE_SHIFT);
		if (first >= prba_pkg::PAGE_COUNT || pages > prba_pkg::PAGE_COUNT - first) begin
			res.status = prba_pkg::STAT_REL_REJECT;
			return;
		end
		for (int i = 0; i < pages; i++)
			page_used[first + i] = 1'b0;
	endtask

	// Mostly allocations of a few pages and releases of runs handed out earlier;
	// the rest is malformed or out-of-window releases and odd sizes.
	function automatic page_op_t make_item();
		page_op_t op;
		int       pick;
		int       idx;
		op.command = ($urandom_range(99) < 55) ? prba_pkg::CMD_ALLOC : prba_pkg::CMD_RELEASE;
		op.address = $urandom();
		op.size_bytes = '0;
		pick = $urandom_range(99);
		if (op.command == prba_pkg::CMD_ALLOC) begin
			if (pick < 70)
				op.size_bytes = $urandom_range(1, 16) << prba_pkg::PAGE_SHIFT;
			else if (pick < 85)
				op.size_bytes = $urandom_range(17, 1100) << prba_pkg::PAGE_SHIFT;
			else if (pick < 93)
				op.size_bytes = '0;
			else
				op.size_bytes = $urandom();
			if ($urandom_range(1) == 1)
				op.size_bytes[prba_pkg::PAGE_SHIFT-1:0] =
					prba_pkg::PAGE_SHIFT'($urandom_range(4095));
		end else if (pick < 75 && live_runs.size() != 0) begin
			idx = $urandom_range(live_runs.size() - 1);
			op.address = live_runs[idx].address;
			op.size_bytes = live_runs[idx].size_bytes;
			if ($urandom_range(99) < 30)
				live_runs.delete(idx);
		end else begin
			case ($urandom_range(5))
				0: begin
					op.size_bytes = $urandom();
				end
				1: begin
					op.address = win_base - ($urandom_range(1, 16) << prba_pkg::PAGE_SHIFT);
					op.size_bytes = $urandom_range(0, 8) << prba_pkg::PAGE_SHIFT;
				end
				2: begin
					op.address = win_base + ($urandom_range(1023) << prba_pkg::PAGE_SHIFT)
						+ $urandom_range(1, 4095);
					op.size_bytes = $urandom_range(0, 8) << prba_pkg::PAGE_SHIFT;
				end
				3: begin
					op.address = win_base + ($urandom_range(1023) << prba_pkg::PAGE_SHIFT);
					op.size_bytes = ($urandom_range(0, 8) << prba_pkg::PAGE_SHIFT)
						+ $urandom_range(1, 4095);
				end
				4: begin
					op.address = win_base
						+ ($urandom_range(1000, 1100) << prba_pkg::PAGE_SHIFT);
					op.size_bytes = $urandom_range(0, 200) << prba_pkg::PAGE_SHIFT;
				end
				default: begin
					op.address = win_base + ($urandom_range(1023) << prba_pkg::PAGE_SHIFT);
					op.size_bytes = $urandom_range(0, 16) << prba_pkg::PAGE_SHIFT;
				end
			endcase
		end
		return op;
	endfunction

	task automatic queue_op(input logic [0:0] cmd, input logic [31:0] size,
			input logic [31:0] addr);
		item_queue.push_back(page_op_t'{command: cmd, size_bytes: size, address: addr});
	endtask

	task automatic wait_drained();
		while (item_queue.size() != 0 || in_valid || pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		int seen;
		seen = cfg_beats;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		while (cfg_beats == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int send_pct, input int stall_pct, input int hold,
			input logic [31:0] base, input logic [10:0] lo_page, input logic [10:0] hi_page,
			input int count);
		int issued;
		write_register(prba_pkg::CFG_WIN_BASE, base);
		write_register(prba_pkg::CFG_WIN_LO, {21'd0, lo_page});
		write_register(prba_pkg::CFG_WIN_HI, {21'd0, hi_page});
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		hold_cycles_left = hold;
		issued = 0;
		while (issued < count) begin
			if (item_queue.size() < 3) begin
				item_queue.push_back(make_item());
				issued++;
			end
			@(posedge clk);
		end
		wait_drained();
	endtask

	// sampling side: register writes, accepted items and results
	always @(posedge clk) begin
		page_op_t    op;
		op_outcome_t res;
		op_outcome_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				cfg_beats <= cfg_beats + 1;
			end
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				op = page_op_t'{command: command, size_bytes: size_bytes, address: address};
				predict_page_op(op, res);
				pending_outcomes.push_back(res);
				items_accepted++;
				if (op.command == prba_pkg::CMD_ALLOC) begin
					if (res.status == prba_pkg::STAT_DONE)
						allocs_granted++;
					else
						allocs_refused++;
				end else if (res.status == prba_pkg::STAT_DONE) begin
					releases_done++;
				end else begin
					releases_rejected++;
				end
			end
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result beat: run_address=%h status=%0d",
							run_address, status);
				end else begin
					want = pending_outcomes.pop_front();
					results_checked++;
					if (run_address !== want.run_address || status !== want.status) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"result %0d: expected run_address=%h status=%0d, ",
								"got run_address=%h status=%0d"},
								results_checked, want.run_address, want.status,
								run_address, status);
					end
				end
			end
		end
	end

	// item driver
	always @(negedge clk) begin
		page_op_t op;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				op = item_queue.pop_front();
				in_valid <= 1'b1;
				command <= op.command;
				size_bytes <= op.size_bytes;
				address <= op.address;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted down on its own
	always @(negedge clk) begin
		if (hold_cycles_left != 0)
			hold_cycles_left <= hold_cycles_left - 1;
	end

	always @(negedge clk) begin
		out_stall <= (hold_cycles_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [10:0] lo_rand;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed beats at reset register values: base 0, window 0..1024
		queue_op(prba_pkg::CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0000_0FFF, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0000_1000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0000_807B, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_1000, 32'h003F_F000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_1000, 32'h003F_F001);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_0064, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_0000, 32'h0040_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_5000, 32'h003F_C000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_0000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_4000, 32'h001F_4000);
		queue_op(prba_pkg::CMD_RELEASE, 32'hFFFF_F000, 32'hFFFF_F000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h003F_9000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h003F_7000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0040_0000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0040_0000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0040_0000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0040_0FFF, 32'h0000_0000);
		queue_op(prba_pkg::CMD_ALLOC, 32'h0000_1000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0040_0000, 32'h0000_0000);
		queue_op(prba_pkg::CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
		wait_drained();

		run_phase(0, 0, 0, 32'h0010_0000, 11'd0, 11'd1024, 120);
		// top window page wraps the result address past 2^32
		run_phase(80, 0, 0, 32'hFFFF_F000, 11'd1000, 11'd1024, 120);
		run_phase(0, 80, 0, $urandom() & 32'hFFFF_F000, 11'd0, 11'd2047, 120);
		run_phase(32, 32, 0, 32'h1234_5678, 11'd600, 11'd0, 60);
		run_phase(32, 32, 0, 32'h0000_0000, 11'd2047, 11'd2047, 40);
		// receiver holds off while items keep coming
		run_phase(0, 0, 400, 32'h0000_0000, 11'd0, 11'd1024, 120);
		lo_rand = 11'($urandom_range(0, 900));
		run_phase(32, 32, 0, $urandom() & 32'hFFFF_F000, lo_rand,
			11'($urandom_range(int'(lo_rand) + 50, 1024)), 120);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			error_count++;
			$display("%0d results never arrived", pending_outcomes.size());
		end
		$display({"covered %0d beats: %0d runs granted, %0d allocations refused, ",
			"%0d releases applied, %0d rejected"},
			items_accepted, allocs_granted, allocs_refused, releases_done, releases_rejected);
		$display("%0d results compared over %0d cycles, %0d errors",
			results_checked, cycle_count, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
sv/prba_pkg.sv
sv/prba_ctrl.sv
sv/prba_dp.sv
sv/page_run_bitmap_allocator_unit.sv
tb/sv/tb_page_run_bitmap_allocator_unit.sv
